>>> rtl/scllc_pkg.sv
// ----------------------------------------------------------------------------
// scllc_pkg
// Shared types, constants and command tables for the serial command-line
// LED control block.
// ----------------------------------------------------------------------------
package scllc_pkg;

  localparam int unsigned LineDepth = 10;
  localparam int unsigned FillW     = $clog2(LineDepth);

  localparam int unsigned CmdCount  = 7;
  localparam int unsigned CmdMaxLen = 8;
  localparam int unsigned HelpCmd   = 6;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChBs = 8'h08;

  // Result queue sizing (depth must be a power of two)
  localparam int unsigned ResQDepth = 4;
  localparam int unsigned ResQPtrW  = $clog2(ResQDepth);
  localparam int unsigned ResQCntW  = $clog2(ResQDepth + 1);

  typedef enum logic [2:0] {
    KindEcho   = 3'd0,
    KindErase  = 3'd1,
    KindAccept = 3'd2,
    KindReject = 3'd3,
    KindHelp   = 3'd4
  } result_kind_e;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   echo_byte;
    logic [7:0]   led_state;
    logic         last;
  } result_t;

  // Up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  typedef logic [7:0] line_t [LineDepth];

  localparam logic [7:0] CmdText [CmdCount][CmdMaxLen] = '{
    '{"L", "E", "D", "7", " ", "O", "N", 8'h00},
    '{"L", "E", "D", "7", " ", "O", "F", "F"},
    '{"L", "E", "D", "6", " ", "O", "N", 8'h00},
    '{"L", "E", "D", "6", " ", "O", "F", "F"},
    '{"L", "E", "D", "5", " ", "O", "N", 8'h00},
    '{"L", "E", "D", "5", " ", "O", "F", "F"},
    '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] CmdLen [CmdCount] = '{
    4'd7, 4'd8, 4'd7, 4'd8, 4'd7, 4'd8, 4'd4
  };

  // LED bit touched by each LED command, and whether it sets or clears it
  localparam logic [2:0] CmdLedBit [HelpCmd] = '{
    3'd7, 3'd7, 3'd6, 3'd6, 3'd5, 3'd5
  };
  localparam logic CmdLedOn [HelpCmd] = '{
    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
  };

  // Line matches command c: text bytes equal, then a zero byte terminates.
  function automatic logic cmd_match(line_t line, int unsigned c);
    logic m;
    m = 1'b1;
    for (int unsigned k = 0; k < CmdMaxLen; k++) begin
      if ((4'(k) < CmdLen[c]) && (line[k] != CmdText[c][k])) begin
        m = 1'b0;
      end
    end
    for (int unsigned k = 0; k <= CmdMaxLen; k++) begin
      if ((4'(k) == CmdLen[c]) && (line[k] != 8'h00)) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/scllc_rx_if.sv
// ----------------------------------------------------------------------------
// scllc_rx_if
// Received-byte channel: valid/ready handshake with one raw byte.
// ----------------------------------------------------------------------------
interface scllc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/scllc_res_if.sv
// ----------------------------------------------------------------------------
// scllc_res_if
// Result channel: valid/ready handshake with kind, echo byte, LED state and last-result flag.
// ----------------------------------------------------------------------------
interface scllc_res_if;
  import scllc_pkg::*;

  logic         valid;
  logic         ready;
  result_kind_e result_kind;
  logic [7:0]   echo_byte;
  logic [7:0]   led_state;
  logic         last_result;

  modport source (output valid, output result_kind, output echo_byte,
                  output led_state, output last_result, input ready);
  modport sink   (input valid, input result_kind, input echo_byte,
                  input led_state, input last_result, output ready);
endinterface

>>> rtl/scllc_core.sv
// ----------------------------------------------------------------------------
// scllc_core
// Line buffer, fill count and LED register; decodes one accepted byte per
// cycle into zero, one or two results.
// ----------------------------------------------------------------------------
module scllc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        rx_byte_i,
  output scllc_pkg::push_t  push_o
);
  import scllc_pkg::*;

  line_t            line_q, line_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       led_q, led_d;

  logic [CmdCount-1:0] hit;
  logic [FillW:0]      fill_inc;
  result_kind_e        cr_kind;

  always_comb begin
    for (int unsigned c = 0; c < CmdCount; c++) begin
      hit[c] = cmd_match(line_q, c);
    end
  end

  assign fill_inc = {1'b0, fill_q} + {{FillW{1'b0}}, 1'b1};

  always_comb begin
    line_d  = line_q;
    fill_d  = fill_q;
    led_d   = led_q;
    cr_kind = KindReject;
    push_o  = '0;

    if (acc_i) begin
      if (rx_byte_i == ChCr) begin
        for (int unsigned c = 0; c < HelpCmd; c++) begin
          if (hit[c]) begin
            led_d[CmdLedBit[c]] = CmdLedOn[c];
          end
        end
        priority if (hit[HelpCmd]) begin
          cr_kind = KindHelp;
        end else if (|hit[HelpCmd-1:0]) begin
          cr_kind = KindAccept;
        end else begin
          cr_kind = KindReject;
        end
        for (int unsigned i = 0; i < LineDepth; i++) begin
          line_d[i] = 8'h00;
        end
        fill_d       = '0;
        push_o.num   = 2'd1;
        push_o.first = '{kind: cr_kind, echo_byte: 8'h00, led_state: led_d, last: 1'b1};
      end else if (rx_byte_i == ChBs) begin
        // Backspace on an empty line gives no result
        if (fill_q != '0) begin
          fill_d         = fill_q - {{(FillW-1){1'b0}}, 1'b1};
          line_d[fill_d] = 8'h00;
          push_o.num     = 2'd1;
          push_o.first   = '{kind: KindErase, echo_byte: 8'h00, led_state: led_q,
                             last: 1'b1};
        end
      end else begin
        line_d[fill_q] = rx_byte_i;
        if (fill_inc >= (FillW+1)'(LineDepth)) begin
          // Line overflow: echo, then reject and drop the line
          for (int unsigned i = 0; i < LineDepth; i++) begin
            line_d[i] = 8'h00;
          end
          fill_d        = '0;
          push_o.num    = 2'd2;
          push_o.first  = '{kind: KindEcho, echo_byte: rx_byte_i, led_state: led_q,
                            last: 1'b0};
          push_o.second = '{kind: KindReject, echo_byte: 8'h00, led_state: led_q,
                            last: 1'b1};
        end else begin
          fill_d       = fill_inc[FillW-1:0];
          push_o.num   = 2'd1;
          push_o.first = '{kind: KindEcho, echo_byte: rx_byte_i, led_state: led_q,
                           last: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < LineDepth; i++) begin
        line_q[i] <= 8'h00;
      end
      fill_q <= '0;
      led_q  <= 8'h00;
    end else begin
      line_q <= line_d;
      fill_q <= fill_d;
      led_q  <= led_d;
    end
  end

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FillW'(LineDepth))
    else $error("fill count reached line depth");

  a_cr_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && rx_byte_i == ChCr) |=> (fill_q == '0 && line_q[0] == 8'h00))
    else $error("line not cleared after carriage return");

  a_led_only_on_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_i && rx_byte_i == ChCr) |=> $stable(led_q))
    else $error("LED register changed without a command");

  a_two_only_on_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.num == 2'd2) |-> (acc_i && fill_inc >= (FillW+1)'(LineDepth)))
    else $error("second result without line overflow");

endmodule

>>> rtl/scllc_resq.sv
// ----------------------------------------------------------------------------
// scllc_resq
// Result queue: takes one or two results per cycle, hands out one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
module scllc_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scllc_pkg::push_t   push_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output scllc_pkg::result_t out_res_o
);
  import scllc_pkg::*;

  result_t              mem_q [ResQDepth];
  logic [ResQPtrW-1:0]  wr_q, rd_q;
  logic [ResQCntW-1:0]  cnt_q;
  logic                 pop;
  logic [ResQPtrW-1:0]  wr_next;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  // Room for a worst-case pair regardless of what leaves this cycle
  assign in_ready_o  = (cnt_q <= ResQCntW'(ResQDepth - 2));
  assign wr_next     = wr_q + {{(ResQPtrW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + ResQPtrW'(push_i.num);
      rd_q  <= rd_q + ResQPtrW'(pop);
      cnt_q <= cnt_q + ResQCntW'(push_i.num) - ResQCntW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResQCntW'(ResQDepth))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> in_ready_o)
    else $error("push while queue lacks room");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd2) |-> (!push_i.first.last && push_i.second.last))
    else $error("result pair marks wrong last result");

endmodule

>>> rtl/serial_command_line_led_control.sv
// ----------------------------------------------------------------------------
// serial_command_line_led_control
// Serial command-line front end that drives LED bits 7..5.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while the result queue has room
// and is decoded in the same cycle against the line buffer; its results go
// into a four-entry result queue, so the byte channel keeps flowing while up
// to two results wait on the result channel. The queue sets the rate: a byte is
// accepted whenever at most two entries are held, and a byte that overflows
// the ten-byte line (echo plus rejection) takes two result transactions. A
// backspace on an empty line yields no result.
module serial_command_line_led_control (
  input  logic               clk_i,
  input  logic               rst_ni,
  scllc_rx_if.sink           rx_i,
  scllc_res_if.source        res_o
);
  import scllc_pkg::*;

  push_t   push;
  result_t out_res;
  logic    acc;

  assign acc = rx_i.valid && rx_i.ready;

  scllc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .rx_byte_i (rx_i.rx_byte),
    .push_o    (push)
  );

  scllc_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_ready_o  (rx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_res_o   (out_res)
  );

  assign res_o.result_kind = out_res.kind;
  assign res_o.echo_byte   = out_res.echo_byte;
  assign res_o.led_state   = out_res.led_state;
  assign res_o.last_result = out_res.last;

endmodule

>>> sim/tb_serial_command_line_led_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_command_line_led_control
// Self-checking bench for the serial command-line LED control block. A short
// directed byte list is followed by random command lines: mostly well-formed
// commands, plus corrupted lines, overflowing lines and backspace runs. Every
// accepted byte is decoded by a local line/LED predictor, and each result
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_serial_command_line_led_control;
  import scllc_pkg::*;

  localparam int TotalItems  = 1150;
  localparam int IdleLimit   = 4000;
  localparam int HoldoffLen  = 400;
  localparam int HoldoffAt   = 500;
  localparam int DrainCycles = 16;

  typedef enum int {
    CmdLed7On, CmdLed7Off, CmdLed6On, CmdLed6Off, CmdLed5On, CmdLed5Off,
    CmdHelp, CmdNone
  } cmd_e;
  localparam int CmdNum = 7;

  // One directed byte; typed rows carry their own expectation
  typedef struct packed {
    logic [7:0]   b;
    logic         typed;
    logic         none;
    result_kind_e kind;
    logic [7:0]   led;
  } dir_row_t;

  localparam int DirRows = 21;
  localparam dir_row_t DirectedRows [DirRows] = '{
    '{ChCr,  1'b1, 1'b0, KindReject, 8'h00},
    '{ChBs,  1'b1, 1'b1, KindEcho,   8'h00},  // empty line: no result
    '{8'hFF, 1'b1, 1'b0, KindEcho,   8'h00},
    '{ChBs,  1'b1, 1'b0, KindErase,  8'h00},
    '{8'h00, 1'b1, 1'b0, KindEcho,   8'h00},
    '{ChCr,  1'b1, 1'b0, KindReject, 8'h00},  // line starts with a zero byte
    '{"H",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"E",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"L",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"Q",   1'b0, 1'b0, KindEcho,   8'h00},
    '{ChBs,  1'b0, 1'b0, KindEcho,   8'h00},
    '{"P",   1'b0, 1'b0, KindEcho,   8'h00},
    '{ChCr,  1'b1, 1'b0, KindHelp,   8'h00},
    '{"L",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"E",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"D",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"7",   1'b0, 1'b0, KindEcho,   8'h00},
    '{" ",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"O",   1'b0, 1'b0, KindEcho,   8'h00},
    '{"N",   1'b0, 1'b0, KindEcho,   8'h00},
    '{ChCr,  1'b1, 1'b0, KindAccept, 8'h80}
  };

  string cmd_str [CmdNum] = '{
    "LED7 ON", "LED7 OFF", "LED6 ON", "LED6 OFF", "LED5 ON", "LED5 OFF", "HELP"
  };

  logic clk_i;
  logic rst_ni;

  scllc_rx_if  rx_if ();
  scllc_res_if res_if ();

  serial_command_line_led_control uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Predictor state
  logic [7:0] line_buf [LineDepth];
  int         line_fill;
  logic [7:0] led_reg;
  result_t    step_res [2];
  int         step_n;

  result_t    pending_q [$];
  result_t    head;
  int         fail_count;
  int         items_sent;
  int         idle_cycles;
  int         burst_left;

  // Expectation of the byte currently offered (travels with the data)
  logic         row_typed;
  logic         row_none;
  result_kind_e row_kind;
  logic [7:0]   row_led;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [7:0] line_at(input int k);
    return (k < LineDepth) ? line_buf[k] : 8'h00;
  endfunction

  function automatic void clear_line();
    for (int k = 0; k < LineDepth; k++) line_buf[k] = 8'h00;
    line_fill = 0;
  endfunction

  function automatic void push_step(input result_kind_e kind, input logic [7:0] echo);
    step_res[step_n] = '{kind: kind, echo_byte: echo, led_state: led_reg, last: 1'b0};
    step_n++;
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    cmd_e hit;
    logic ok;
    int   n;
    step_n = 0;
    if (b == ChCr) begin
      hit = CmdNone;
      for (int c = 0; c < CmdNum; c++) begin
        n  = cmd_str[c].len();
        ok = (line_at(n) == 8'h00);  // zero byte ends the line
        for (int k = 0; k < n; k++) begin
          if (line_at(k) != cmd_str[c][k]) ok = 1'b0;
        end
        if (ok) hit = cmd_e'(c);
      end
      case (hit)
        CmdLed7On:  led_reg[7] = 1'b1;
        CmdLed7Off: led_reg[7] = 1'b0;
        CmdLed6On:  led_reg[6] = 1'b1;
        CmdLed6Off: led_reg[6] = 1'b0;
        CmdLed5On:  led_reg[5] = 1'b1;
        CmdLed5Off: led_reg[5] = 1'b0;
        default: ;
      endcase
      clear_line();
      if (hit == CmdNone) push_step(KindReject, 8'h00);
      else if (hit == CmdHelp) push_step(KindHelp, 8'h00);
      else push_step(KindAccept, 8'h00);
    end else if (b == ChBs) begin
      if (line_fill != 0) begin
        line_fill--;
        line_buf[line_fill] = 8'h00;
        push_step(KindErase, 8'h00);
      end
    end else begin
      line_buf[line_fill] = b;
      line_fill++;
      push_step(KindEcho, b);
      if (line_fill >= LineDepth) begin
        // line overflow: echo, then reject and drop the line
        clear_line();
        push_step(KindReject, 8'h00);
      end
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChCr || b == ChBs);
    return b;
  endfunction

  // Monitor: predict on accepted bytes, check accepted results
  initial begin
    clear_line();
    led_reg    = 8'h00;
    fail_count = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        decode_rx_byte(rx_if.rx_byte);
        if (row_typed) begin
          if (!row_none) begin
            pending_q.push_back('{kind: row_kind,
                                  echo_byte: (row_kind == KindEcho) ? rx_if.rx_byte : 8'h00,
                                  led_state: row_led, last: 1'b1});
          end
        end else begin
          for (int i = 0; i < step_n; i++) pending_q.push_back(step_res[i]);
        end
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result transaction: result_kind %0d echo_byte %0h",
                 res_if.result_kind, res_if.echo_byte);
          fail_count++;
        end else begin
          head = pending_q.pop_front();
          if (res_if.result_kind !== head.kind) begin
            $error("result_kind: expected %0d, got %0d", head.kind, res_if.result_kind);
            fail_count++;
          end
          if (res_if.echo_byte !== head.echo_byte) begin
            $error("echo_byte: expected %0h, got %0h", head.echo_byte, res_if.echo_byte);
            fail_count++;
          end
          if (res_if.led_state !== head.led_state) begin
            $error("led_state: expected %0h, got %0h", head.led_state, res_if.led_state);
            fail_count++;
          end
          if (res_if.last_result !== head.last) begin
            $error("last_result: expected %0b, got %0b", head.last, res_if.last_result);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: rotating stall patterns plus one long hold-off
  initial begin
    int  rcv_cycle;
    bit  holdoff_done;
    rcv_cycle    = 0;
    holdoff_done = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!holdoff_done && items_sent >= HoldoffAt) begin
        holdoff_done = 1;
        res_if.ready <= 1'b0;
        repeat (HoldoffLen) @(posedge clk_i);
      end else begin
        case (rcv_cycle[9:8])
          2'd0: res_if.ready <= 1'b1;
          2'd1: res_if.ready <= 1'($urandom_range(0, 1));
          2'd2: res_if.ready <= (rcv_cycle % 5) != 0;
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
        rcv_cycle++;
      end
    end
  end

  // Offer one byte; a new burst may start with an idle gap
  task automatic offer(input logic [7:0] b, input logic typed, input logic none,
                       input result_kind_e kind, input logic [7:0] led);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    row_typed     <= typed;
    row_none      <= none;
    row_kind      <= kind;
    row_led       <= led;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  initial begin
    logic [7:0] seq [$];
    string      s;
    int         sel;
    int         c;
    int         p;
    int         g;
    bit         typo;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    row_typed     <= 1'b0;
    row_none      <= 1'b0;
    row_kind      <= KindEcho;
    row_led       <= 8'h00;
    items_sent = 0;
    burst_left = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      offer(DirectedRows[i].b, DirectedRows[i].typed, DirectedRows[i].none,
            DirectedRows[i].kind, DirectedRows[i].led);
    end

    while (items_sent < TotalItems) begin
      seq.delete();
      sel = $urandom_range(0, 99);
      c   = $urandom_range(0, CmdNum - 1);
      s   = cmd_str[c];
      if (sel < 55) begin
        // well-formed command, maybe with a corrected typo or zero-terminated tail
        typo = ($urandom_range(0, 3) == 0);
        p    = $urandom_range(0, s.len() - 1);
        for (int k = 0; k < s.len(); k++) begin
          if (typo && k == p) begin
            seq.push_back(plain_byte());
            seq.push_back(ChBs);
          end
          seq.push_back(s[k]);
        end
        if ($urandom_range(0, 4) == 0) begin
          seq.push_back(8'h00);
          g = $urandom_range(0, LineDepth - 2 - s.len());
          for (int k = 0; k < g; k++) seq.push_back(plain_byte());
        end
        seq.push_back(ChCr);
      end else if (sel < 70) begin
        // near miss: truncated, altered or extended command
        for (int k = 0; k < s.len(); k++) seq.push_back(s[k]);
        case ($urandom_range(0, 2))
          0: void'(seq.pop_back());
          1: seq[$urandom_range(0, s.len() - 1)] = plain_byte();
          default: seq.push_back(plain_byte());
        endcase
        seq.push_back(ChCr);
      end else if (sel < 82) begin
        // line overflow
        g = $urandom_range(LineDepth, LineDepth + 4);
        for (int k = 0; k < g; k++) seq.push_back(plain_byte());
        if ($urandom_range(0, 1) == 0) seq.push_back(ChCr);
      end else if (sel < 92) begin
        // backspace runs, some past the start of the line
        g = $urandom_range(0, 4);
        for (int k = 0; k < g; k++) seq.push_back(plain_byte());
        g = $urandom_range(1, 6);
        for (int k = 0; k < g; k++) seq.push_back(ChBs);
      end else begin
        g = $urandom_range(1, 12);
        for (int k = 0; k < g; k++) seq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (seq[i]) offer(seq[i], 1'b0, 1'b0, KindEcho, 8'h00);
    end

    rx_if.valid <= 1'b0;
    // let the monitor log the last accepted byte before watching the queue
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
